### design/bnms_pkg.sv
// Package for box non-max suppression: payload structs and register indexes.
// Used by the top level.
`timescale 1ns / 1ps
`default_nettype none
package bnms_pkg;
  localparam int unsigned CfgIdxThr = 0;
  localparam int unsigned CfgIdxMin = 1;
  localparam logic [15:0] ThrReset = 16'd32768;
  localparam logic [15:0] MinReset = 16'd39322;

  typedef struct packed {
    logic        last_box;
    logic [7:0]  obj_class;
    logic [15:0] score;
    logic [11:0] box_height;
    logic [11:0] box_width;
    logic [11:0] y_pos;
    logic [11:0] x_pos;
  } in_word_t;

  typedef struct packed {
    logic        last;
    logic        valid_res;
    logic [7:0]  out_class;
    logic [15:0] out_score;
    logic [11:0] out_height;
    logic [11:0] out_width;
    logic [11:0] out_y;
    logic [11:0] out_x;
  } out_word_t;
endpackage
`default_nettype wire

### design/bnms_iou.sv
// Pairwise overlap test: one register stage (areas and intersection),
// then the threshold compare. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bnms_iou (
  input  wire logic        clk,
  input  wire logic [11:0] ax, ay, aw, ah,
  input  wire logic [11:0] bx, by, bw, bh,
  input  wire logic [15:0] thr,
  output logic             hit
);
  logic [12:0] ae_x, be_x, ae_y, be_y, x1, y1, x2, y2;
  logic signed [14:0] w, h;
  logic [13:0] wc, hc;
  logic [27:0] inter_r, inter_nxt;
  logic [24:0] areas_r, areas_nxt;
  logic signed [29:0] uni;
  logic [45:0] lhs;
  logic [46:0] rhs;

  always_comb begin
    ae_x = {1'b0, ax} + {1'b0, aw};
    be_x = {1'b0, bx} + {1'b0, bw};
    ae_y = {1'b0, ay} + {1'b0, ah};
    be_y = {1'b0, by} + {1'b0, bh};
    x1 = (ax > bx) ? {1'b0, ax} : {1'b0, bx};
    y1 = (ay > by) ? {1'b0, ay} : {1'b0, by};
    x2 = (ae_x < be_x) ? ae_x : be_x;
    y2 = (ae_y < be_y) ? ae_y : be_y;
    w = $signed({2'b0, x2}) - $signed({2'b0, x1}) + 15'sd1;
    h = $signed({2'b0, y2}) - $signed({2'b0, y1}) + 15'sd1;
    wc = w[14] ? 14'd0 : w[13:0];
    hc = h[14] ? 14'd0 : h[13:0];
    inter_nxt = wc * hc;
    areas_nxt = {1'b0, {12'b0, aw} * {12'b0, ah}} + {1'b0, {12'b0, bw} * {12'b0, bh}};
    uni = $signed({5'b0, areas_r}) - $signed({2'b0, inter_r});
    lhs = {2'b0, inter_r, 16'b0};
    rhs = {1'b0, thr} * {1'b0, uni[28:0]};
    hit = !uni[29] && (uni != 30'sd0) && ({1'b0, lhs} > rhs);
  end

  always_ff @(posedge clk) begin
    inter_r <= inter_nxt;
    areas_r <= areas_nxt;
  end
endmodule
`default_nettype wire

### design/box_non_max_suppression.sv
// Top level of box non-max suppression: box store, ranking and suppression
// sequencer, result register. Depends on bnms_pkg and bnms_iou.
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_ready  | bnms_pkg::in_word_t
//  out_    | output    | out_valid/out_ready| bnms_pkg::out_word_t
//  cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
// A box that does not close the set is stored while fewer than MAX_BOXES are
// held, else dropped. A closing box starts ranking of the stored boxes (one
// score compare a cycle), then suppression of later-ranked overlaps of each
// kept box, then emission of kept words, which waits out out_ready stalls.
// in_ready is low from the closing box until the final word is registered.
// Reset (synchronous, rst_n low) empties the set and restores registers.
`timescale 1ns / 1ps
`default_nettype none
module box_non_max_suppression #(
  parameter int unsigned MAX_BOXES = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire bnms_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output bnms_pkg::out_word_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [15:0]         cfg_wdata
);
  localparam int unsigned IW = $clog2(MAX_BOXES);
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);

  typedef enum logic [14:0] {
    S_LOAD  = 15'b000000000000001, S_RI    = 15'b000000000000010,
    S_RIW   = 15'b000000000000100, S_RJW   = 15'b000000000001000,
    S_PI    = 15'b000000000010000, S_PIW   = 15'b000000000100000,
    S_PIG   = 15'b000000001000000, S_PJW   = 15'b000000010000000,
    S_PJG   = 15'b000000100000000, S_PJH   = 15'b000001000000000,
    S_EI    = 15'b000010000000000, S_EIW   = 15'b000100000000000,
    S_EIG   = 15'b001000000000000, S_EPUSH = 15'b010000000000000,
    S_ELAST = 15'b100000000000000
  } state_t;

  state_t st_r, st_nxt;
  logic [15:0] thr_r, thr_nxt, min_r, min_nxt, si_r, si_nxt;
  logic [47:0] geo [MAX_BOXES];
  logic [23:0] sc [MAX_BOXES];
  logic [IW-1:0] order [MAX_BOXES];
  logic [47:0] geo_q, ga_r, ga_nxt;
  logic [23:0] sc_q;
  logic [IW-1:0] ord_q, geo_ra, sc_ra, ord_ra, ord_wa, ord_wd;
  logic [IW-1:0] oj_r, oj_nxt, oe_r, oe_nxt, r_r, r_nxt, rank_w;
  logic ord_we, ld_we, gt, hit, keep;
  logic any_r, any_nxt, out_v_r, out_v_nxt;
  logic [MAX_BOXES-1:0] sup_r, sup_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, i_r, i_nxt, j_r, j_nxt, e_r, e_nxt;
  logic [CW-1:0] nm1, i_inc, j_inc, e_inc;
  bnms_pkg::out_word_t out_r, out_nxt, hold_r, hold_nxt, cand;

  assign in_ready = (st_r == S_LOAD);
  assign out_valid = out_v_r;
  assign out_data = out_r;

  bnms_iou u_iou (
    .clk(clk),
    .ax(ga_r[11:0]), .ay(ga_r[23:12]), .aw(ga_r[35:24]), .ah(ga_r[47:36]),
    .bx(geo_q[11:0]), .by(geo_q[23:12]), .bw(geo_q[35:24]), .bh(geo_q[47:36]),
    .thr(thr_r), .hit(hit)
  );

  assign nm1 = cnt_r - CW'(1);
  assign i_inc = i_r + CW'(1);
  assign j_inc = j_r + CW'(1);
  assign e_inc = e_r + CW'(1);
  assign gt = (sc_q[15:0] > si_r) || ((sc_q[15:0] == si_r) && (j_r < i_r));
  assign rank_w = r_r + IW'(gt);
  assign keep = !sup_r[oe_r] && (sc_q[15:0] >= min_r);
  assign ld_we = (st_r == S_LOAD) && in_valid && (cnt_r < CW'(MAX_BOXES));

  always_comb begin
    cand = '0;
    cand.out_x = geo_q[11:0];
    cand.out_y = geo_q[23:12];
    cand.out_width = geo_q[35:24];
    cand.out_height = geo_q[47:36];
    cand.out_score = sc_q[15:0];
    cand.out_class = sc_q[23:16];
    cand.valid_res = 1'b1;
    cand.last = 1'b0;
  end

  always_comb begin
    st_nxt = st_r;
    thr_nxt = thr_r;
    min_nxt = min_r;
    si_nxt = si_r;
    ga_nxt = ga_r;
    oj_nxt = oj_r;
    oe_nxt = oe_r;
    r_nxt = r_r;
    any_nxt = any_r;
    sup_nxt = sup_r;
    cnt_nxt = cnt_r;
    i_nxt = i_r;
    j_nxt = j_r;
    e_nxt = e_r;
    hold_nxt = hold_r;
    out_nxt = out_r;
    out_v_nxt = out_v_r && !out_ready;
    geo_ra = '0;
    sc_ra = '0;
    ord_ra = '0;
    ord_we = 1'b0;
    ord_wa = '0;
    ord_wd = '0;
    if (cfg_we && cfg_index == 1'(bnms_pkg::CfgIdxThr)) thr_nxt = cfg_wdata;
    if (cfg_we && cfg_index == 1'(bnms_pkg::CfgIdxMin)) min_nxt = cfg_wdata;
    case (st_r)
      S_LOAD: begin
        if (in_valid) begin
          if (cnt_r < CW'(MAX_BOXES)) cnt_nxt = cnt_r + CW'(1);
          if (in_data.last_box) begin
            i_nxt = '0;
            st_nxt = S_RI;
          end
        end
      end
      S_RI: begin
        sc_ra = i_r[IW-1:0];
        st_nxt = S_RIW;
      end
      S_RIW: begin
        si_nxt = sc_q[15:0];
        sc_ra = '0;
        j_nxt = '0;
        r_nxt = '0;
        st_nxt = S_RJW;
      end
      S_RJW: begin
        if (j_r == nm1) begin
          ord_we = 1'b1;
          ord_wa = rank_w;
          ord_wd = i_r[IW-1:0];
          if (i_r == nm1) begin
            i_nxt = '0;
            sup_nxt = '0;
            st_nxt = S_PI;
          end else begin
            i_nxt = i_inc;
            sc_ra = i_inc[IW-1:0];
            st_nxt = S_RIW;
          end
        end else begin
          r_nxt = rank_w;
          j_nxt = j_inc;
          sc_ra = j_inc[IW-1:0];
        end
      end
      S_PI: begin
        if (i_inc >= cnt_r) begin
          e_nxt = '0;
          any_nxt = 1'b0;
          st_nxt = S_EI;
        end else begin
          ord_ra = i_r[IW-1:0];
          st_nxt = S_PIW;
        end
      end
      S_PIW: begin
        if (sup_r[ord_q]) begin
          i_nxt = i_inc;
          st_nxt = S_PI;
        end else begin
          geo_ra = ord_q;
          j_nxt = i_inc;
          st_nxt = S_PIG;
        end
      end
      S_PIG: begin
        ga_nxt = geo_q;
        ord_ra = j_r[IW-1:0];
        st_nxt = S_PJW;
      end
      S_PJW: begin
        oj_nxt = ord_q;
        geo_ra = ord_q;
        st_nxt = S_PJG;
      end
      S_PJG: st_nxt = S_PJH;
      S_PJH: begin
        if (hit) sup_nxt[oj_r] = 1'b1;
        if (j_r == nm1) begin
          i_nxt = i_inc;
          st_nxt = S_PI;
        end else begin
          j_nxt = j_inc;
          ord_ra = j_inc[IW-1:0];
          st_nxt = S_PJW;
        end
      end
      S_EI: begin
        if (e_r == cnt_r) st_nxt = S_ELAST;
        else begin
          ord_ra = e_r[IW-1:0];
          st_nxt = S_EIW;
        end
      end
      S_EIW: begin
        oe_nxt = ord_q;
        geo_ra = ord_q;
        sc_ra = ord_q;
        st_nxt = S_EIG;
      end
      S_EIG: begin
        geo_ra = oe_r;
        sc_ra = oe_r;
        if (keep && any_r) st_nxt = S_EPUSH;
        else begin
          if (keep) begin
            hold_nxt = cand;
            any_nxt = 1'b1;
          end
          e_nxt = e_inc;
          st_nxt = S_EI;
        end
      end
      S_EPUSH: begin
        geo_ra = oe_r;
        sc_ra = oe_r;
        if (!out_v_r || out_ready) begin
          out_nxt = hold_r;
          out_v_nxt = 1'b1;
          hold_nxt = cand;
          e_nxt = e_inc;
          st_nxt = S_EI;
        end
      end
      S_ELAST: begin
        if (!out_v_r || out_ready) begin
          if (any_r) out_nxt = hold_r;
          else out_nxt = '0;
          out_nxt.last = 1'b1;
          out_v_nxt = 1'b1;
          cnt_nxt = '0;
          sup_nxt = '0;
          st_nxt = S_LOAD;
        end
      end
      default: st_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld_we) begin
      geo[cnt_r[IW-1:0]] <= {in_data.box_height, in_data.box_width,
                             in_data.y_pos, in_data.x_pos};
      sc[cnt_r[IW-1:0]] <= {in_data.obj_class, in_data.score};
    end
    if (ord_we) order[ord_wa] <= ord_wd;
    geo_q <= geo[geo_ra];
    sc_q <= sc[sc_ra];
    ord_q <= order[ord_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; thr_r <= bnms_pkg::ThrReset; min_r <= bnms_pkg::MinReset;
      si_r <= '0; ga_r <= '0; oj_r <= '0; oe_r <= '0; r_r <= '0;
      any_r <= 1'b0; sup_r <= '0; cnt_r <= '0; i_r <= '0; j_r <= '0; e_r <= '0;
      hold_r <= '0; out_r <= '0; out_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt; thr_r <= thr_nxt; min_r <= min_nxt;
      si_r <= si_nxt; ga_r <= ga_nxt; oj_r <= oj_nxt; oe_r <= oe_nxt; r_r <= r_nxt;
      any_r <= any_nxt; sup_r <= sup_nxt; cnt_r <= cnt_nxt;
      i_r <= i_nxt; j_r <= j_nxt; e_r <= e_nxt;
      hold_r <= hold_nxt; out_r <= out_nxt; out_v_r <= out_v_nxt;
    end
  end
endmodule
`default_nettype wire
